>>> src/lr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants of the line rasterizer: command codes, register indexes
// and register reset values.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic REG_FB_BASE = 1'b0;
    localparam logic REG_WPL     = 1'b1;

    localparam int APB_ADDR_BITS = 3;
    localparam int DATA_BITS     = 32;
    localparam int WPL_BITS      = 13;

    localparam logic [DATA_BITS-1:0] FB_BASE_RESET = 32'h2800_0000;
    localparam logic [WPL_BITS-1:0]  WPL_RESET     = 13'd800;

endpackage

>>> src/lr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_cmd_if / lr_pix_if
// Valid/ready channels for line commands and for generated pixels.
// ----------------------------------------------------------------------------
interface lr_cmd_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [31:0]           color;

    modport source (output valid, command, start_x, start_y, end_x, end_y, color,
                    input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, color,
                    output ready);
endinterface

interface lr_pix_if #(parameter int COORD_BITS = 12) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [31:0]           word_address;
    logic [31:0]           pixel_color;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, word_address, pixel_color,
                    last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, word_address, pixel_color,
                    last_pixel, output ready);
endinterface

>>> src/lr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_step
// Bresenham line state. A start request loads the line set-up; a step request
// captures the current pixel into the stage register and advances the walk, if the line has pixels left.
// ----------------------------------------------------------------------------
module lr_step
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_acc,
    input  logic                  i_command,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    input  logic [31:0]           i_color,
    input  logic                  i_adv,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [31:0]           o_color,
    output logic                  o_last
);

    localparam int ERR_BITS = COORD_BITS + 3;

    logic [COORD_BITS-1:0]      r_cur_x, r_cur_y, r_left, r_adx, r_ady;
    logic signed [ERR_BITS-1:0] r_err;
    logic                       r_xdn, r_ydn, r_ymaj;
    logic [31:0]                r_line_color;
    logic                       r_valid;
    logic [COORD_BITS-1:0]      r_px, r_py;
    logic [31:0]                r_pcol;
    logic                       r_plast;

    // Start set-up.
    logic                  n_xdn, n_ydn, n_ymaj;
    logic [COORD_BITS-1:0] n_adx, n_ady, n_major_st;

    // Step datapath.
    logic [COORD_BITS-1:0]      w_major, w_minor, w_x_mv, w_y_mv;
    logic signed [ERR_BITS-1:0] w_e_add, w_e_sub;
    logic                       w_bump, w_emit;

    always_comb begin
        n_xdn      = i_end_x < i_start_x;
        n_ydn      = i_end_y < i_start_y;
        n_adx      = n_xdn ? i_start_x - i_end_x : i_end_x - i_start_x;
        n_ady      = n_ydn ? i_start_y - i_end_y : i_end_y - i_start_y;
        n_ymaj     = n_ady > n_adx;
        n_major_st = n_ymaj ? n_ady : n_adx;
    end

    always_comb begin
        w_major = r_ymaj ? r_ady : r_adx;
        w_minor = r_ymaj ? r_adx : r_ady;
        w_e_add = r_err + $signed({2'b00, w_minor, 1'b0});
        w_e_sub = w_e_add - $signed({2'b00, w_major, 1'b0});
        // A non-negative error term moves the walk along the minor axis too.
        w_bump  = !w_e_add[ERR_BITS-1];
        w_x_mv  = r_xdn ? r_cur_x - COORD_BITS'(1) : r_cur_x + COORD_BITS'(1);
        w_y_mv  = r_ydn ? r_cur_y - COORD_BITS'(1) : r_cur_y + COORD_BITS'(1);
        w_emit  = i_acc && (i_command == CMD_STEP) && (r_left != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_err        <= '0;
            r_left       <= '0;
            r_adx        <= '0;
            r_ady        <= '0;
            r_xdn        <= 1'b0;
            r_ydn        <= 1'b0;
            r_ymaj       <= 1'b0;
            r_line_color <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_acc && (i_command == CMD_START)) begin
                r_cur_x      <= i_start_x;
                r_cur_y      <= i_start_y;
                r_err        <= ERR_BITS'(0) - {3'b000, n_major_st};
                r_left       <= n_major_st;
                r_adx        <= n_adx;
                r_ady        <= n_ady;
                r_xdn        <= n_xdn;
                r_ydn        <= n_ydn;
                r_ymaj       <= n_ymaj;
                r_line_color <= i_color;
            end else if (w_emit) begin
                if (r_ymaj) begin
                    r_cur_y <= w_y_mv;
                    if (w_bump) begin
                        r_cur_x <= w_x_mv;
                    end
                end else begin
                    r_cur_x <= w_x_mv;
                    if (w_bump) begin
                        r_cur_y <= w_y_mv;
                    end
                end
                r_err  <= w_bump ? w_e_sub : w_e_add;
                r_left <= r_left - COORD_BITS'(1);
            end
            if (i_acc) begin
                r_valid <= w_emit;
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_px    <= r_cur_x;
            r_py    <= r_cur_y;
            r_pcol  <= r_line_color;
            r_plast <= r_left == COORD_BITS'(1);
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel_x = r_px;
    assign o_pixel_y = r_py;
    assign o_color   = r_pcol;
    assign o_last    = r_plast;

endmodule

>>> src/lr_addr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lr_addr
// Output register stage: forms the frame-buffer byte address of a pixel from
// the row stride multiply and holds the pixel until it is taken.
// ----------------------------------------------------------------------------
module lr_addr
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic [31:0]           i_color,
    input  logic                  i_last,
    input  logic [DATA_BITS-1:0]  i_fb_base,
    input  logic [WPL_BITS-1:0]   i_wpl,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [31:0]           o_word_address,
    output logic [31:0]           o_pixel_color,
    output logic                  o_last_pixel
);

    localparam int PROD_BITS = COORD_BITS + WPL_BITS;

    logic [PROD_BITS-1:0] w_prod;
    logic [31:0]          w_word, w_addr;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [31:0]           r_addr, r_col;
    logic                  r_last;

    always_comb begin
        w_prod = {WPL_BITS'(0), i_pixel_y} * {COORD_BITS'(0), i_wpl};
        w_word = 32'(w_prod) + 32'(i_pixel_x);
        // Words are four bytes; the sum wraps at 32 bits.
        w_addr = i_fb_base + {w_word[29:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px   <= i_pixel_x;
            r_py   <= i_pixel_y;
            r_addr <= w_addr;
            r_col  <= i_color;
            r_last <= i_last;
        end
    end

    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_word_address = r_addr;
    assign o_pixel_color  = r_col;
    assign o_last_pixel   = r_last;

endmodule

>>> src/line_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line generator with APB configuration of frame-buffer base and
// row stride. Emits one pixel with its word address per step request.
// ----------------------------------------------------------------------------
// A pixel is registered in the step stage, then in the output stage, where
// the stride multiply sits. Throughput: one request per cycle when not
// stalled; start requests and steps with no active line produce no pixel.
// Reset (synchronous, active low): no line active, pipeline empty,
// fb_base = 0x28000000, words_per_line = 800.
// ----------------------------------------------------------------------------
module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    lr_cmd_if.sink                   i_cmd,
    lr_pix_if.source                 o_pix,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready
);

    logic [DATA_BITS-1:0] r_fb_base;
    logic [WPL_BITS-1:0]  r_wpl;
    logic                 r_out_valid;

    logic                  w_s1_valid, w_s1_adv, w_acc, w_s1_last;
    logic [COORD_BITS-1:0] w_s1_x, w_s1_y;
    logic [31:0]           w_s1_color;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_base <= FB_BASE_RESET;
            r_wpl     <= WPL_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_FB_BASE: r_fb_base <= pwdata;
                REG_WPL:     r_wpl     <= pwdata[WPL_BITS-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FB_BASE: prdata = r_fb_base;
            REG_WPL:     prdata = DATA_BITS'(r_wpl);
            default:     prdata = '0;
        endcase
    end

    // Two-stage pipeline; each stage moves on when the one after it is free.
    assign w_s1_adv    = !r_out_valid || o_pix.ready;
    assign i_cmd.ready = !w_s1_valid || w_s1_adv;
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    lr_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_command (i_cmd.command),
        .i_start_x (i_cmd.start_x),
        .i_start_y (i_cmd.start_y),
        .i_end_x   (i_cmd.end_x),
        .i_end_y   (i_cmd.end_y),
        .i_color   (i_cmd.color),
        .i_adv     (w_s1_adv),
        .o_valid   (w_s1_valid),
        .o_pixel_x (w_s1_x),
        .o_pixel_y (w_s1_y),
        .o_color   (w_s1_color),
        .o_last    (w_s1_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= w_s1_valid;
        end
    end

    lr_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .i_clk          (i_clk),
        .i_load         (w_s1_adv && w_s1_valid),
        .i_pixel_x      (w_s1_x),
        .i_pixel_y      (w_s1_y),
        .i_color        (w_s1_color),
        .i_last         (w_s1_last),
        .i_fb_base      (r_fb_base),
        .i_wpl          (r_wpl),
        .o_pixel_x      (o_pix.pixel_x),
        .o_pixel_y      (o_pix.pixel_y),
        .o_word_address (o_pix.word_address),
        .o_pixel_color  (o_pix.pixel_color),
        .o_last_pixel   (o_pix.last_pixel)
    );

    assign o_pix.valid = r_out_valid;

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer testbench
// Drives line starts and pixel steps into the rasterizer and checks every
// generated pixel, field by field, against a Bresenham predictor kept in
// step with each accepted request. A short directed table comes first. Then
// phases of random lines follow under different frame-buffer settings and
// idle patterns. A long receiver hold-off makes the pipeline back up.
// ----------------------------------------------------------------------------
module testbench;
    import lr_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int PIPE_SLACK = 4;
    localparam int PHASE_ITEMS = 250;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t      pixel_x;
        coord_t      pixel_y;
        logic [31:0] word_address;
        logic [31:0] pixel_color;
        logic        last_pixel;
    } pixel_t;

    typedef struct packed {
        logic        command;
        coord_t      sx;
        coord_t      sy;
        coord_t      ex;
        coord_t      ey;
        logic [31:0] color;
        bit          typed;
        bit          has_pixel;
        pixel_t      pixel;
    } stim_row_t;

    // Rows marked typed carry their own expectation; the others use the predictor.
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{CMD_STEP,  12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'hffff_ffff, 1'b1, 1'b0, '0},
        '{CMD_START, 12'd0, 12'd0, 12'd3, 12'd0, 32'hffff_ffff, 1'b1, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
          '{12'd0, 12'd0, 32'h2800_0000, 32'hffff_ffff, 1'b0}},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
          '{12'd1, 12'd0, 32'h2800_0004, 32'hffff_ffff, 1'b0}},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
          '{12'd2, 12'd0, 32'h2800_0008, 32'hffff_ffff, 1'b1}},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, '0},
        '{CMD_START, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'h0, 1'b1, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, '0},
        '{CMD_START, 12'hfff, 12'hfff, 12'd0, 12'd0, 32'h1234_5678, 1'b1, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
          '{12'hfff, 12'hfff, 32'h28c8_337c, 32'h1234_5678, 1'b0}},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_START, 12'd0, 12'hfff, 12'd5, 12'd0, 32'ha5a5_a5a5, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_START, 12'd100, 12'd200, 12'd100, 12'd203, 32'h5a5a_5a5a, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_START, 12'd7, 12'd9, 12'd11, 12'd7, 32'h0f0f_0f0f, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0},
        '{CMD_STEP,  12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, '0}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0]     pwdata;
    logic [DATA_BITS-1:0]     prdata;
    logic                     pready;

    lr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_bus ();
    lr_pix_if #(.COORD_BITS(COORD_BITS)) pix_bus ();

    line_rasterizer #(.COORD_BITS(COORD_BITS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_pix   (pix_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Sideband that travels with each request: a typed expectation, if any.
    bit     typed_row;
    bit     typed_has_pixel;
    pixel_t typed_pixel;

    pixel_t pending_pixels[$];
    int     mismatch_count;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_cycles_left;

    logic [31:0]         cfg_fb_base;
    logic [WPL_BITS-1:0] cfg_wpl;

    coord_t      line_x;
    coord_t      line_y;
    int          line_err;
    coord_t      line_left;
    coord_t      line_adx;
    coord_t      line_ady;
    bit          line_xdown;
    bit          line_ydown;
    bit          line_ymajor;
    logic [31:0] line_color;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("line_rasterizer test failed");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 100)
            $display("%0t: %s mismatch, got %h expected %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Bresenham step: a start loads the line, a step emits the current pixel
    // and then advances along the major axis.
    function automatic void rasterize_request(input stim_row_t row, output bit produced,
                                              output pixel_t pix);
        produced = 1'b0;
        pix = '0;
        if (row.command == CMD_START) begin
            line_xdown  = row.ex < row.sx;
            line_ydown  = row.ey < row.sy;
            line_adx    = line_xdown ? row.sx - row.ex : row.ex - row.sx;
            line_ady    = line_ydown ? row.sy - row.ey : row.ey - row.sy;
            line_ymajor = line_ady > line_adx;
            line_left   = line_ymajor ? line_ady : line_adx;
            line_err    = -int'(line_left);
            line_x      = row.sx;
            line_y      = row.sy;
            line_color  = row.color;
        end else if (line_left != 0) begin
            produced         = 1'b1;
            pix.pixel_x      = line_x;
            pix.pixel_y      = line_y;
            pix.word_address = cfg_fb_base
                               + ((32'(line_y) * 32'(cfg_wpl) + 32'(line_x)) << 2);
            pix.pixel_color  = line_color;
            pix.last_pixel   = (line_left == 1);
            if (line_ymajor) begin
                line_y   = line_ydown ? line_y - 1'b1 : line_y + 1'b1;
                line_err = line_err + 2 * int'(line_adx);
                if (line_err >= 0) begin
                    line_x   = line_xdown ? line_x - 1'b1 : line_x + 1'b1;
                    line_err = line_err - 2 * int'(line_ady);
                end
            end else begin
                line_x   = line_xdown ? line_x - 1'b1 : line_x + 1'b1;
                line_err = line_err + 2 * int'(line_ady);
                if (line_err >= 0) begin
                    line_y   = line_ydown ? line_y - 1'b1 : line_y + 1'b1;
                    line_err = line_err - 2 * int'(line_adx);
                end
            end
            line_left = line_left - 1'b1;
        end
    endfunction

    // Results are checked before new requests are predicted, so the order
    // within one edge is fixed.
    always @(posedge i_clk) begin
        pixel_t got;
        pixel_t want;
        pixel_t predicted;
        bit     produced;
        if (i_rst_n && pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) begin
            got = '{pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.word_address,
                    pix_bus.pixel_color, pix_bus.last_pixel};
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel_x", 32'(got.pixel_x), 32'h0);
            end else begin
                want = pending_pixels.pop_front();
                if (got.pixel_x !== want.pixel_x)
                    report_mismatch("pixel_x", 32'(got.pixel_x), 32'(want.pixel_x));
                if (got.pixel_y !== want.pixel_y)
                    report_mismatch("pixel_y", 32'(got.pixel_y), 32'(want.pixel_y));
                if (got.word_address !== want.word_address)
                    report_mismatch("word_address", got.word_address, want.word_address);
                if (got.pixel_color !== want.pixel_color)
                    report_mismatch("pixel_color", got.pixel_color, want.pixel_color);
                if (got.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", 32'(got.last_pixel), 32'(want.last_pixel));
            end
        end
        if (i_rst_n && cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1) begin
            rasterize_request('{cmd_bus.command, cmd_bus.start_x, cmd_bus.start_y,
                                cmd_bus.end_x, cmd_bus.end_y, cmd_bus.color,
                                1'b0, 1'b0, '0}, produced, predicted);
            if (typed_row) begin
                if (typed_has_pixel)
                    pending_pixels.push_back(typed_pixel);
            end else if (produced) begin
                pending_pixels.push_back(predicted);
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        pix_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles_left > 0) begin
                pix_bus.ready    <= 1'b0;
                hold_cycles_left <= hold_cycles_left - 1;
            end else begin
                pix_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input stim_row_t row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= row.command;
        cmd_bus.start_x <= row.sx;
        cmd_bus.start_y <= row.sy;
        cmd_bus.end_x   <= row.ex;
        cmd_bus.end_y   <= row.ey;
        cmd_bus.color   <= row.color;
        typed_row       <= row.typed;
        typed_has_pixel <= row.has_pixel;
        typed_pixel     <= row.pixel;
        @(posedge i_clk);
        while (cmd_bus.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Steps after the last pixel may still be in flight, hence the slack.
    task automatic wait_for_pixels();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_FB_BASE)
            cfg_fb_base = value;
        else
            cfg_wpl = value[WPL_BITS-1:0];
        @(posedge i_clk);
    endtask

    function automatic stim_row_t make_row(input logic command, input coord_t sx,
                                           input coord_t sy, input coord_t ex,
                                           input coord_t ey, input logic [31:0] color);
        stim_row_t row;
        row         = '0;
        row.command = command;
        row.sx      = sx;
        row.sy      = sy;
        row.ex      = ex;
        row.ey      = ey;
        row.color   = color;
        return row;
    endfunction

    function automatic coord_t near_coord(input coord_t c, input int span);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return coord_t'(v);
    endfunction

    // Mostly complete short lines with random content, some long lines cut
    // short by the next start, and a little noise of steps with no line.
    task automatic run_random(input int target);
        int     done_items;
        int     kind;
        int     span;
        int     len;
        int     steps;
        int     i;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        done_items = 0;
        while (done_items < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_request(make_row(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                                      coord_t'($urandom), coord_t'($urandom), $urandom));
            end else begin
                sx   = coord_t'($urandom_range(0, COORD_MAX));
                sy   = coord_t'($urandom_range(0, COORD_MAX));
                span = (kind < 80) ? $urandom_range(0, 24) : COORD_MAX;
                ex   = near_coord(sx, span);
                ey   = near_coord(sy, span);
                len  = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > len)
                    len = (ey > sy) ? ey - sy : sy - ey;
                send_request(make_row(CMD_START, sx, sy, ex, ey, $urandom));
                done_items++;
                if (kind < 80) begin
                    steps = len + $urandom_range(0, 2);
                    if ($urandom_range(0, 9) == 0)
                        steps = $urandom_range(0, len);
                end else begin
                    steps = $urandom_range(1, 40);
                end
                for (i = 0; i < steps; i++) begin
                    send_request(make_row(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                                          coord_t'($urandom), coord_t'($urandom),
                                          $urandom));
                    if (i < len)
                        done_items++;
                end
            end
        end
    endtask

    initial begin
        int phase;
        int i;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.command <= CMD_START;
        cmd_bus.start_x <= '0;
        cmd_bus.start_y <= '0;
        cmd_bus.end_x   <= '0;
        cmd_bus.end_y   <= '0;
        cmd_bus.color   <= '0;
        typed_row       <= 1'b0;
        typed_has_pixel <= 1'b0;
        typed_pixel     <= '0;
        hold_cycles_left = 0;
        mismatch_count   = 0;
        send_idle_pct    = 18;
        recv_idle_pct    = 86;
        cfg_fb_base      = FB_BASE_RESET;
        cfg_wpl          = WPL_RESET;
        line_x      = '0;
        line_y      = '0;
        line_err    = 0;
        line_left   = '0;
        line_adx    = '0;
        line_ady    = '0;
        line_xdown  = 1'b0;
        line_ydown  = 1'b0;
        line_ymajor = 1'b0;
        line_color  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 25; i++)
            send_request(DIRECTED_ROWS[i]);

        for (phase = 0; phase < 6; phase++) begin
            wait_for_pixels();
            case (phase)
                1: begin
                    write_register(REG_FB_BASE, 32'hffff_ffff);
                    write_register(REG_WPL, 32'h0000_1fff);
                end
                2: begin
                    write_register(REG_FB_BASE, 32'h0);
                    write_register(REG_WPL, 32'h0);
                end
                3: begin
                    write_register(REG_FB_BASE, $urandom);
                    write_register(REG_WPL, 32'd1);
                end
                4: begin
                    write_register(REG_FB_BASE, $urandom);
                    write_register(REG_WPL, 32'd4096);
                end
                5: begin
                    write_register(REG_FB_BASE, $urandom);
                    write_register(REG_WPL, $urandom);
                end
                default: ;
            endcase
            send_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 86 : 0;
            recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 18 : 0;
            if (phase == 5) begin
                // A long line while the receiver holds off fills the pipeline
                // and must back-pressure the step requests.
                send_request(make_row(CMD_START, 12'd0, 12'd0, 12'd400, 12'd150,
                                      32'hc3c3_3c3c));
                hold_cycles_left <= 200;
                for (i = 0; i < 400; i++)
                    send_request(make_row(CMD_STEP, '0, '0, '0, '0, 32'h0));
            end
            run_random(PHASE_ITEMS);
        end

        wait_for_pixels();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("line_rasterizer test passed");
        else
            $display("line_rasterizer test failed");
        $finish;
    end

endmodule
